@@ hdl/sbc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_pkg
// shared types and codes for the segment versus box classifier
// ----------------------------------------------------------------------------
package sbc_pkg;

	localparam int REL_W       = 2;
	localparam int OUT_TDATA_W = 8;
	localparam int REG_IDX_W   = 2;

	// relation codes
	localparam logic [REL_W-1:0] REL_OUTSIDE = 2'd0;
	localparam logic [REL_W-1:0] REL_OVERLAP = 2'd1;
	localparam logic [REL_W-1:0] REL_INSIDE  = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_LEFT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOTTOM = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RIGHT  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_TOP    = 2'd3;

	// edge order in edge_ok
	localparam int EDGE_LEFT   = 0;
	localparam int EDGE_RIGHT  = 1;
	localparam int EDGE_BOTTOM = 2;
	localparam int EDGE_TOP    = 3;

	typedef struct packed {
		logic       in_p;      // start point inside box
		logic       in_q;      // end point inside box
		logic       axis;      // vertical or horizontal segment
		logic       line_hit;  // axis segment crosses box
		logic [3:0] edge_ok;   // edge coordinate within segment span
	} sbc_flags_t;

endpackage
`default_nettype wire

@@ hdl/sbc_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_prep
// first pipeline stage: endpoint tests, axis cases and coordinate differences
// ----------------------------------------------------------------------------
module sbc_prep
	import sbc_pkg::*;
#(
	parameter int W = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  in_valid,
	input  wire signed [W-1:0]   box_left,
	input  wire signed [W-1:0]   box_bottom,
	input  wire signed [W-1:0]   box_right,
	input  wire signed [W-1:0]   box_top,
	input  wire signed [W-1:0]   px,
	input  wire signed [W-1:0]   py,
	input  wire signed [W-1:0]   qx,
	input  wire signed [W-1:0]   qy,
	output logic                 valid_s1,
	output sbc_flags_t           flags_s1,
	output logic signed [W:0]    dl_s1,
	output logic signed [W:0]    dr_s1,
	output logic signed [W:0]    db_s1,
	output logic signed [W:0]    dt_s1,
	output logic signed [W:0]    ndx_s1,
	output logic signed [W:0]    ndy_s1,
	output logic signed [W:0]    mdx_s1,
	output logic signed [W:0]    mdy_s1
);

	localparam int DW = W + 1;

	logic signed [DW-1:0] pxe, pye, qxe, qye;
	logic signed [DW-1:0] dx_pos, dx_neg, dy_pos, dy_neg;
	logic                 x_dec, y_dec, vert, horz;
	sbc_flags_t           flags;

	assign pxe = DW'(px);
	assign pye = DW'(py);
	assign qxe = DW'(qx);
	assign qye = DW'(qy);

	assign dx_pos = qxe - pxe;
	assign dx_neg = pxe - qxe;
	assign dy_pos = qye - pye;
	assign dy_neg = pye - qye;
	assign x_dec  = qx < px;
	assign y_dec  = qy < py;
	assign vert   = px == qx;
	assign horz   = py == qy;

	always_comb begin
		flags.in_p = (box_left <= px) && (px <= box_right) &&
			(box_bottom <= py) && (py <= box_top);
		flags.in_q = (box_left <= qx) && (qx <= box_right) &&
			(box_bottom <= qy) && (qy <= box_top);
		flags.axis = vert || horz;
		if (vert) begin
			flags.line_hit = ((py >= box_bottom) != (qy >= box_bottom)) &&
				(box_left <= px) && (px <= box_right);
		end else begin
			flags.line_hit = ((px >= box_left) != (qx >= box_left)) &&
				(box_bottom <= py) && (py <= box_top);
		end
		// edge within [min, max] of the segment span
		flags.edge_ok[EDGE_LEFT]   = ((px <= box_left) || (qx <= box_left)) &&
			((px >= box_left) || (qx >= box_left));
		flags.edge_ok[EDGE_RIGHT]  = ((px <= box_right) || (qx <= box_right)) &&
			((px >= box_right) || (qx >= box_right));
		flags.edge_ok[EDGE_BOTTOM] = ((py <= box_bottom) || (qy <= box_bottom)) &&
			((py >= box_bottom) || (qy >= box_bottom));
		flags.edge_ok[EDGE_TOP]    = ((py <= box_top) || (qy <= box_top)) &&
			((py >= box_top) || (qy >= box_top));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1 <= flags;
			dl_s1    <= DW'(box_left) - pxe;
			dr_s1    <= DW'(box_right) - pxe;
			db_s1    <= DW'(box_bottom) - pye;
			dt_s1    <= DW'(box_top) - pye;
			// direction normalized so the x step (or y step) is non-negative
			ndx_s1   <= x_dec ? dx_neg : dx_pos;
			ndy_s1   <= x_dec ? dy_neg : dy_pos;
			mdx_s1   <= y_dec ? dx_neg : dx_pos;
			mdy_s1   <= y_dec ? dy_neg : dy_pos;
		end
	end

endmodule
`default_nettype wire

@@ hdl/segment_box_classify.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_box_classify
// classifies a line segment as outside, overlapping or inside a clip box
// ----------------------------------------------------------------------------
// pipeline: prep, multiply and compare stages, each registered, from item accept to m_tvalid
// throughput: one item per cycle, set by the fully pipelined multiply stage
// the pipeline stalls as a whole only while the output item waits on m_tready
// reset: arst_n clears all valid bits and sets the box to zero
// ----------------------------------------------------------------------------
module segment_box_classify
	import sbc_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// configuration write port
	input  wire                                   cfg_we,
	input  wire [REG_IDX_W-1:0]                   cfg_index,
	input  wire [COORD_WIDTH-1:0]                 cfg_data,
	// segment input: start_x, start_y, end_x, end_y (lowest bits first)
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire [((4*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
	// result output: relation
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	output logic [OUT_TDATA_W-1:0]                m_tdata
);

	localparam int W  = COORD_WIDTH;
	localparam int PW = 2 * (W + 1);

	// clip box registers
	logic signed [W-1:0] box_left_q, box_bottom_q, box_right_q, box_top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q   <= '0;
			box_bottom_q <= '0;
			box_right_q  <= '0;
			box_top_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT:   box_left_q   <= cfg_data;
				REG_BOTTOM: box_bottom_q <= cfg_data;
				REG_RIGHT:  box_right_q  <= cfg_data;
				REG_TOP:    box_top_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances when the output register is free or drains
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// input fields
	logic signed [W-1:0] start_x, start_y, end_x, end_y;
	assign start_x = s_tdata[W-1:0];
	assign start_y = s_tdata[2*W-1:W];
	assign end_x   = s_tdata[3*W-1:2*W];
	assign end_y   = s_tdata[4*W-1:3*W];

	// stage 1: endpoint tests and differences
	logic                valid_s1;
	sbc_flags_t          flags_s1;
	logic signed [W:0]   dl_s1, dr_s1, db_s1, dt_s1;
	logic signed [W:0]   ndx_s1, ndy_s1, mdx_s1, mdy_s1;

	sbc_prep #(
		.W (W)
	) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_valid   (s_tvalid),
		.box_left   (box_left_q),
		.box_bottom (box_bottom_q),
		.box_right  (box_right_q),
		.box_top    (box_top_q),
		.px         (start_x),
		.py         (start_y),
		.qx         (end_x),
		.qy         (end_y),
		.valid_s1   (valid_s1),
		.flags_s1   (flags_s1),
		.dl_s1      (dl_s1),
		.dr_s1      (dr_s1),
		.db_s1      (db_s1),
		.dt_s1      (dt_s1),
		.ndx_s1     (ndx_s1),
		.ndy_s1     (ndy_s1),
		.mdx_s1     (mdx_s1),
		.mdy_s1     (mdy_s1)
	);

	// stage 2: exact cross products, each edge test is lo <= mid <= hi
	logic                 valid_s2;
	sbc_flags_t           flags_s2;
	logic signed [PW-1:0] vlo_s2, vhi_s2;   // y bounds scaled by x step
	logic signed [PW-1:0] hlo_s2, hhi_s2;   // x bounds scaled by y step
	logic signed [PW-1:0] mid_l_s2, mid_r_s2, mid_b_s2, mid_t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s2 <= flags_s1;
			vlo_s2   <= db_s1 * ndx_s1;
			vhi_s2   <= dt_s1 * ndx_s1;
			hlo_s2   <= dl_s1 * mdy_s1;
			hhi_s2   <= dr_s1 * mdy_s1;
			mid_l_s2 <= dl_s1 * ndy_s1;
			mid_r_s2 <= dr_s1 * ndy_s1;
			mid_b_s2 <= db_s1 * mdx_s1;
			mid_t_s2 <= dt_s1 * mdx_s1;
		end
	end

	// stage 3: edge compares and final decision
	logic [3:0]       edge_hit;
	logic [REL_W-1:0] rel;

	always_comb begin
		edge_hit[EDGE_LEFT]   = flags_s2.edge_ok[EDGE_LEFT] &&
			(vlo_s2 <= mid_l_s2) && (mid_l_s2 <= vhi_s2);
		edge_hit[EDGE_RIGHT]  = flags_s2.edge_ok[EDGE_RIGHT] &&
			(vlo_s2 <= mid_r_s2) && (mid_r_s2 <= vhi_s2);
		edge_hit[EDGE_BOTTOM] = flags_s2.edge_ok[EDGE_BOTTOM] &&
			(hlo_s2 <= mid_b_s2) && (mid_b_s2 <= hhi_s2);
		edge_hit[EDGE_TOP]    = flags_s2.edge_ok[EDGE_TOP] &&
			(hlo_s2 <= mid_t_s2) && (mid_t_s2 <= hhi_s2);

		if (flags_s2.in_p != flags_s2.in_q) begin
			rel = REL_OVERLAP;
		end else if (flags_s2.in_p) begin
			rel = REL_INSIDE;
		end else if (flags_s2.axis) begin
			// vertical, horizontal or zero-length segment
			rel = flags_s2.line_hit ? REL_OVERLAP : REL_OUTSIDE;
		end else begin
			rel = (|edge_hit) ? REL_OVERLAP : REL_OUTSIDE;
		end
	end

	// output register
	logic             valid_s3;
	logic [REL_W-1:0] rel_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rel_s3 <= rel;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = {{(OUT_TDATA_W-REL_W){1'b0}}, rel_s3};

	// both endpoints inside must come out as inside
	a_both_inside: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s2 && flags_s2.in_p && flags_s2.in_q |=>
			valid_s3 && rel_s3 == REL_INSIDE)
		else $error("both endpoints inside but relation is not inside");

	// exactly one endpoint inside must come out as overlap
	a_one_inside: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s2 && (flags_s2.in_p != flags_s2.in_q) |=>
			valid_s3 && rel_s3 == REL_OVERLAP)
		else $error("one endpoint inside but relation is not overlap");

	// axis segment with no crossing and both ends out stays outside
	a_axis_miss: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s2 && flags_s2.axis && !flags_s2.line_hit &&
			!flags_s2.in_p && !flags_s2.in_q |=>
			rel_s3 == REL_OUTSIDE)
		else $error("axis segment without crossing reported as touching");

endmodule
`default_nettype wire
